>>> sv/png_sf_pkg.sv
// ----------------------------------------------------------------------------
// PNG scanline filter package
// Shared types and filter type codes.
// ----------------------------------------------------------------------------
package png_sf_pkg;

    localparam logic [2:0] FILTER_NONE    = 3'd0;
    localparam logic [2:0] FILTER_SUB     = 3'd1;
    localparam logic [2:0] FILTER_UP      = 3'd2;
    localparam logic [2:0] FILTER_AVERAGE = 3'd3;
    localparam logic [2:0] FILTER_PAETH   = 3'd4;

    typedef struct packed {
        logic [2:0]  filter_kind;
        logic        sixteen_bit;
        logic        with_alpha;
        logic [10:0] row_pixels;
    } cfg_t;

    // Request held between the line store read and the predictor
    typedef struct packed {
        logic [7:0] raw;
        logic       row_start;
        logic       has_left;
        logic       first_row;
        logic [2:0] slot;
    } stage_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_tag;
        logic       last;
    } result_t;

endpackage

>>> sv/png_scanline_filter_top.sv
// ----------------------------------------------------------------------------
// PNG scanline filter top level
// Filter method 0 (None/Sub/Up/Average/Paeth) over a raw truecolor byte stream.
// ----------------------------------------------------------------------------
// Takes one raw byte per cycle while not held off and returns it filtered; the
// first byte of each row is preceded by its filter type tag, so a row of N
// bytes leaves as N + 1 results. An accepted byte is held in the stage register
// and then in the result queue before it reaches the output. The previous row
// sits in a line store of MAX_WIDTH * 8 bytes that is read and written at the
// same address in the cycle a byte is accepted; the first row of an image uses
// zeros instead. Results pass through a four-entry queue; input is held off
// only while that queue is near full. The user must write configuration over
// the APB port only while no bytes are in flight; the block does not enforce it.
module png_scanline_filter_top
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  raw_byte,
    input  logic        image_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        is_tag,
    output logic        last
);

    png_sf_pkg::cfg_t    cfg;
    png_sf_pkg::stage_t  stage;
    png_sf_pkg::result_t res_first, res_second, res_out;
    logic [7:0]          up_byte;
    logic                stage_valid, space_ok, advance, two_results;

    assign advance = stage_valid && space_ok;

    png_sf_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    png_sf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .raw_byte    (raw_byte),
        .image_start (image_start),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage       (stage),
        .up_byte     (up_byte)
    );

    png_sf_predict u_predict
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .filter_kind (cfg.filter_kind),
        .stage       (stage),
        .up_byte     (up_byte),
        .advance     (advance),
        .res_first   (res_first),
        .res_second  (res_second),
        .two_results (two_results)
    );

    png_sf_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (advance),
        .push_two   (two_results),
        .res_first  (res_first),
        .res_second (res_second),
        .space_ok   (space_ok),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res_out    (res_out)
    );

    assign out_byte = res_out.data;
    assign is_tag   = res_out.is_tag;
    assign last     = res_out.last;

endmodule

>>> sv/png_sf_regs.sv
// ----------------------------------------------------------------------------
// PNG scanline filter configuration registers
// APB-style register file holding filter type and image geometry.
// ----------------------------------------------------------------------------
module png_sf_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output png_sf_pkg::cfg_t   cfg
);

    localparam logic [1:0] REG_FILTER_KIND = 2'd0;
    localparam logic [1:0] REG_SIXTEEN_BIT = 2'd1;
    localparam logic [1:0] REG_WITH_ALPHA  = 2'd2;
    localparam logic [1:0] REG_ROW_PIXELS  = 2'd3;

    png_sf_pkg::cfg_t cfg_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_kind <= png_sf_pkg::FILTER_NONE;
            cfg_reg.sixteen_bit <= 1'b0;
            cfg_reg.with_alpha  <= 1'b0;
            cfg_reg.row_pixels  <= 11'd1;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_FILTER_KIND: cfg_reg.filter_kind <= pwdata[2:0];
                REG_SIXTEEN_BIT: cfg_reg.sixteen_bit <= pwdata[0];
                REG_WITH_ALPHA:  cfg_reg.with_alpha  <= pwdata[0];
                REG_ROW_PIXELS:  cfg_reg.row_pixels  <= pwdata[10:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FILTER_KIND: prdata = {29'd0, cfg_reg.filter_kind};
            REG_SIXTEEN_BIT: prdata = {31'd0, cfg_reg.sixteen_bit};
            REG_WITH_ALPHA:  prdata = {31'd0, cfg_reg.with_alpha};
            REG_ROW_PIXELS:  prdata = {21'd0, cfg_reg.row_pixels};
        endcase
    end

endmodule

>>> sv/png_sf_front.sv
// ----------------------------------------------------------------------------
// PNG scanline filter front end
// Row position tracking, previous-row line store and input register.
// ----------------------------------------------------------------------------
module png_sf_front
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  png_sf_pkg::cfg_t    cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          raw_byte,
    input  logic                image_start,
    input  logic                advance,
    output logic                stage_valid,
    output png_sf_pkg::stage_t  stage,
    output logic [7:0]          up_byte
);

    localparam int DEPTH = MAX_WIDTH * 8;
    localparam int PW    = $clog2(DEPTH);
    localparam int RLW   = $clog2(DEPTH + 1);

    logic [7:0]    store_mem [DEPTH];
    logic [7:0]    up_reg;

    logic [PW-1:0] pos_reg, pos_next;
    logic [1:0]    mod3_reg, mod3_next;
    logic [2:0]    mod8_reg, mod8_next;
    logic          first_reg, first_next;
    logic          valid_reg;
    png_sf_pkg::stage_t stage_reg;

    logic          accept;
    logic [10:0]   width_c;
    logic [31:0]   base_len, len_full;
    logic [RLW-1:0] row_len, pos_plus;
    logic [3:0]    bpp;
    logic [PW-1:0] pos_in, pos_eff;
    logic [1:0]    mod3_in, mod3_eff;
    logic [2:0]    mod8_in, mod8_eff;
    logic          first_eff, wrap, row_end;
    logic [2:0]    slot, mod6;

    assign accept      = in_valid && in_ready;
    assign in_ready    = !valid_reg || advance;
    assign stage_valid = valid_reg;
    assign stage       = stage_reg;
    assign up_byte     = up_reg;

    // Clamped width and row length in bytes
    always_comb
    begin
        priority if (cfg.row_pixels == 11'd0)
            width_c = 11'd1;
        else if (32'(cfg.row_pixels) > 32'(MAX_WIDTH))
            width_c = 11'(MAX_WIDTH);
        else
            width_c = cfg.row_pixels;
    end

    assign base_len = cfg.with_alpha ? (32'(width_c) << 2)
                                     : (32'(width_c) + (32'(width_c) << 1));
    assign len_full = cfg.sixteen_bit ? (base_len << 1) : base_len;
    assign row_len  = len_full[RLW-1:0];
    assign bpp      = cfg.with_alpha ? (cfg.sixteen_bit ? 4'd8 : 4'd4)
                                     : (cfg.sixteen_bit ? 4'd6 : 4'd3);

    assign pos_in    = image_start ? '0 : pos_reg;
    assign mod3_in   = image_start ? 2'd0 : mod3_reg;
    assign mod8_in   = image_start ? 3'd0 : mod8_reg;
    assign first_eff = image_start ? 1'b1 : first_reg;
    assign wrap      = RLW'(pos_in) >= row_len;
    assign pos_eff   = wrap ? '0 : pos_in;
    assign mod3_eff  = wrap ? 2'd0 : mod3_in;
    assign mod8_eff  = wrap ? 3'd0 : mod8_in;

    assign pos_plus  = RLW'(pos_eff) + RLW'(1);
    assign row_end   = pos_plus >= row_len;
    assign pos_next  = row_end ? '0 : pos_plus[PW-1:0];
    assign mod3_next = row_end ? 2'd0 : ((mod3_eff == 2'd2) ? 2'd0 : mod3_eff + 2'd1);
    assign mod8_next = row_end ? 3'd0 : mod8_eff + 3'd1;
    assign first_next = row_end ? 1'b0 : first_eff;

    // Position mod 6 from its residues mod 3 and mod 2
    assign mod6 = (mod3_eff[0] == mod8_eff[0]) ? {1'b0, mod3_eff}
                                               : {1'b0, mod3_eff} + 3'd3;

    always_comb
    begin
        unique case ({cfg.sixteen_bit, cfg.with_alpha})
            2'b00: slot = {1'b0, mod3_eff};
            2'b01: slot = {1'b0, mod8_eff[1:0]};
            2'b10: slot = mod6;
            2'b11: slot = mod8_eff;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            mod3_reg  <= 2'd0;
            mod8_reg  <= 3'd0;
            first_reg <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg   <= pos_next;
                mod3_reg  <= mod3_next;
                mod8_reg  <= mod8_next;
                first_reg <= first_next;
            end
            if (accept)
                valid_reg <= 1'b1;
            else if (advance)
                valid_reg <= 1'b0;
        end
    end

    // Read-before-write: the old entry is the byte above this one
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_reg             <= store_mem[pos_eff];
            store_mem[pos_eff] <= raw_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.raw       <= raw_byte;
            stage_reg.row_start <= (pos_eff == '0);
            stage_reg.has_left  <= 32'(pos_eff) >= 32'(bpp);
            stage_reg.first_row <= first_eff;
            stage_reg.slot      <= slot;
        end
    end

endmodule

>>> sv/png_sf_predict.sv
// ----------------------------------------------------------------------------
// PNG scanline filter predictor
// Neighbor registers and the None/Sub/Up/Average/Paeth filter datapath.
// ----------------------------------------------------------------------------
module png_sf_predict
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          filter_kind,
    input  png_sf_pkg::stage_t  stage,
    input  logic [7:0]          up_byte,
    input  logic                advance,
    output png_sf_pkg::result_t res_first,
    output png_sf_pkg::result_t res_second,
    output logic                two_results
);

    logic [7:0] left_reg  [8];
    logic [7:0] upper_reg [8];

    logic [7:0] a, b, c, pred, filt;
    logic [2:0] kind;
    logic [8:0] avg_sum;
    logic [9:0] pa, pb, pc;
    logic [9:0] d_bc, d_ac, d_abc;
    logic [7:0] paeth;
    png_sf_pkg::result_t tag_res, data_res;

    assign a = stage.has_left ? left_reg[stage.slot] : 8'd0;
    assign b = stage.first_row ? 8'd0 : up_byte;
    assign c = (stage.has_left && !stage.first_row) ? upper_reg[stage.slot] : 8'd0;

    assign kind = (filter_kind > png_sf_pkg::FILTER_PAETH) ? png_sf_pkg::FILTER_NONE
                                                           : filter_kind;

    assign avg_sum = 9'(a) + 9'(b);

    // pa = |b - c|, pb = |a - c|, pc = |a + b - 2c|
    assign d_bc  = 10'(b) - 10'(c);
    assign d_ac  = 10'(a) - 10'(c);
    assign d_abc = 10'(a) + 10'(b) - 10'(c) - 10'(c);
    assign pa    = d_bc[9]  ? (10'd0 - d_bc)  : d_bc;
    assign pb    = d_ac[9]  ? (10'd0 - d_ac)  : d_ac;
    assign pc    = d_abc[9] ? (10'd0 - d_abc) : d_abc;

    always_comb
    begin
        priority if (pa <= pb && pa <= pc)
            paeth = a;
        else if (pb <= pc)
            paeth = b;
        else
            paeth = c;
    end

    always_comb
    begin
        case (kind)
            png_sf_pkg::FILTER_SUB:     pred = a;
            png_sf_pkg::FILTER_UP:      pred = b;
            png_sf_pkg::FILTER_AVERAGE: pred = avg_sum[8:1];
            png_sf_pkg::FILTER_PAETH:   pred = paeth;
            default:                    pred = 8'd0;
        endcase
    end

    assign filt = stage.raw - pred;

    assign tag_res.data    = {5'd0, kind};
    assign tag_res.is_tag  = 1'b1;
    assign tag_res.last    = 1'b0;
    assign data_res.data   = filt;
    assign data_res.is_tag = 1'b0;
    assign data_res.last   = 1'b1;

    assign two_results = stage.row_start;
    assign res_first   = stage.row_start ? tag_res : data_res;
    assign res_second  = data_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                left_reg[i]  <= 8'd0;
                upper_reg[i] <= 8'd0;
            end
        end
        else if (advance)
        begin
            left_reg[stage.slot]  <= stage.raw;
            upper_reg[stage.slot] <= b;
        end
    end

endmodule

>>> sv/png_sf_outq.sv
// ----------------------------------------------------------------------------
// PNG scanline filter output queue
// Four-entry result queue taking one or two results per request.
// ----------------------------------------------------------------------------
module png_sf_outq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                push_two,
    input  png_sf_pkg::result_t res_first,
    input  png_sf_pkg::result_t res_second,
    output logic                space_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output png_sf_pkg::result_t res_out
);

    png_sf_pkg::result_t entry_reg [4];
    logic [1:0] head_reg, tail_reg;
    logic [2:0] cnt_reg;
    logic [2:0] push_cnt;
    logic       pop;

    assign out_valid = (cnt_reg != 3'd0);
    assign space_ok  = (cnt_reg <= 3'd2);
    assign res_out   = entry_reg[head_reg];
    assign pop       = out_valid && out_ready;
    assign push_cnt  = push ? (push_two ? 3'd2 : 3'd1) : 3'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 2'd0;
            tail_reg <= 2'd0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            if (pop)
                head_reg <= head_reg + 2'd1;
            tail_reg <= tail_reg + push_cnt[1:0];
            cnt_reg  <= cnt_reg + push_cnt - {2'd0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[tail_reg] <= res_first;
        if (push && push_two)
            entry_reg[tail_reg + 2'd1] <= res_second;
    end

endmodule

>>> sv/png_sf_checker.sv
// ----------------------------------------------------------------------------
// PNG scanline filter checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module png_sf_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       is_tag,
    input  logic       last
);

    // A tag is always followed at once by its row's first filtered byte
    a_tag_then_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && is_tag |=> out_valid && !is_tag)
        else $error("tag not followed by filtered byte");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last != is_tag))
        else $error("last flag inconsistent with tag flag");

    a_tag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_tag |-> out_byte <= {5'd0, png_sf_pkg::FILTER_PAETH})
        else $error("tag byte out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_tag))
        else $error("result changed while stalled");

endmodule

bind png_scanline_filter_top png_sf_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .is_tag    (is_tag),
    .last      (last)
);
